// ----- hdl/box_iou_macros.svh -----
// ----------------------------------------------------------------------------
// box_iou_macros.svh
// Assertion macros shared by the box IoU block; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef BOX_IOU_MACROS_SVH
`define BOX_IOU_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define BIOU_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("box_iou assertion failed");

// Check an implication between two expressions on the same edge.
`define BIOU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    `BIOU_ASSERT(lbl, ck, rn, (ante) |-> (cons))

`else

`define BIOU_ASSERT(lbl, ck, rn, prop)
`define BIOU_ASSERT_IMP(lbl, ck, rn, ante, cons)

`endif

`endif

// ----- hdl/biou_pkg.sv -----
// ----------------------------------------------------------------------------
// biou_pkg
// Shared constants for the box intersection-over-union block.
// ----------------------------------------------------------------------------
`default_nettype none

package biou_pkg;

    // Default width of one signed box coordinate
    localparam int BIOU_COORD_WIDTH = 16;

    // Default number of fractional bits of the ratio
    localparam int BIOU_FRAC_BITS   = 16;

    // Round a bit count up to whole bytes
    function automatic int biou_byte_bits(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/biou_geom.sv -----
// ----------------------------------------------------------------------------
// biou_geom
// First stage: overlap extents clipped at zero and absolute box extents.
// ----------------------------------------------------------------------------
`default_nettype none

module biou_geom
    import biou_pkg::*;
#(
    parameter int COORD_WIDTH = BIOU_COORD_WIDTH
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [8*COORD_WIDTH-1:0]   in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [COORD_WIDTH-1:0]          ovl_w,
    output logic [COORD_WIDTH-1:0]          ovl_h,
    output logic [COORD_WIDTH-1:0]          a_w,
    output logic [COORD_WIDTH-1:0]          a_h,
    output logic [COORD_WIDTH-1:0]          b_w,
    output logic [COORD_WIDTH-1:0]          b_h
);

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0] a_left, a_top, a_right, a_bottom;
    logic signed [W-1:0] b_left, b_top, b_right, b_bottom;
    logic signed [W-1:0] x1, y1, x2, y2;

    logic         valid_reg;
    logic [W-1:0] ovl_w_reg, ovl_h_reg, a_w_reg, a_h_reg, b_w_reg, b_h_reg;
    logic [W-1:0] ovl_w_next, ovl_h_next, a_w_next, a_h_next, b_w_next, b_h_next;

    // |hi - lo| of two signed coordinates; always fits in W unsigned bits
    function automatic logic [W-1:0] abs_diff(input logic signed [W-1:0] hi,
                                              input logic signed [W-1:0] lo);
        logic signed [W:0] d;
        logic signed [W:0] n;
        d = {hi[W-1], hi} - {lo[W-1], lo};
        n = -d;
        return d[W] ? n[W-1:0] : d[W-1:0];
    endfunction

    // max(hi - lo, 0) of two signed coordinates
    function automatic logic [W-1:0] clip_diff(input logic signed [W-1:0] hi,
                                               input logic signed [W-1:0] lo);
        logic signed [W:0] d;
        d = {hi[W-1], hi} - {lo[W-1], lo};
        return d[W] ? '0 : d[W-1:0];
    endfunction

    // Unpack the edges, first field in the lowest bits
    assign a_left   = in_data[0*W +: W];
    assign a_top    = in_data[1*W +: W];
    assign a_right  = in_data[2*W +: W];
    assign a_bottom = in_data[3*W +: W];
    assign b_left   = in_data[4*W +: W];
    assign b_top    = in_data[5*W +: W];
    assign b_right  = in_data[6*W +: W];
    assign b_bottom = in_data[7*W +: W];

    // Overlap corners
    assign x1 = (a_left   > b_left)   ? a_left   : b_left;
    assign y1 = (a_top    > b_top)    ? a_top    : b_top;
    assign x2 = (a_right  < b_right)  ? a_right  : b_right;
    assign y2 = (a_bottom < b_bottom) ? a_bottom : b_bottom;

    // Extents
    always_comb
    begin
        ovl_w_next = clip_diff(x2, x1);
        ovl_h_next = clip_diff(y2, y1);
        a_w_next   = abs_diff(a_right, a_left);
        a_h_next   = abs_diff(a_bottom, a_top);
        b_w_next   = abs_diff(b_right, b_left);
        b_h_next   = abs_diff(b_bottom, b_top);
    end

    // Stage is free when empty or when its content moves on
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load payload on a transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ovl_w_reg <= ovl_w_next;
            ovl_h_reg <= ovl_h_next;
            a_w_reg   <= a_w_next;
            a_h_reg   <= a_h_next;
            b_w_reg   <= b_w_next;
            b_h_reg   <= b_h_next;
        end
    end

    assign out_valid = valid_reg;
    assign ovl_w     = ovl_w_reg;
    assign ovl_h     = ovl_h_reg;
    assign a_w       = a_w_reg;
    assign a_h       = a_h_reg;
    assign b_w       = b_w_reg;
    assign b_h       = b_h_reg;

endmodule

`default_nettype wire

// ----- hdl/biou_area.sv -----
// ----------------------------------------------------------------------------
// biou_area
// Two stages: the three area products, then the union and its zero flag.
// ----------------------------------------------------------------------------
`default_nettype none

module biou_area
    import biou_pkg::*;
#(
    parameter int COORD_WIDTH = BIOU_COORD_WIDTH
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [COORD_WIDTH-1:0]     ovl_w,
    input  wire logic [COORD_WIDTH-1:0]     ovl_h,
    input  wire logic [COORD_WIDTH-1:0]     a_w,
    input  wire logic [COORD_WIDTH-1:0]     a_h,
    input  wire logic [COORD_WIDTH-1:0]     b_w,
    input  wire logic [COORD_WIDTH-1:0]     b_h,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [2*COORD_WIDTH:0]          inter,
    output logic [2*COORD_WIDTH:0]          uni,
    output logic                            uni_zero
);

    localparam int PW = 2 * COORD_WIDTH;
    localparam int RW = PW + 1;

    logic          prod_valid_reg;
    logic          prod_ready;
    logic [PW-1:0] inter_reg, area_a_reg, area_b_reg;
    logic [PW-1:0] inter_next, area_a_next, area_b_next;

    logic          uni_valid_reg;
    logic [RW-1:0] inter_u_reg, uni_reg;
    logic [RW-1:0] uni_next;
    logic          zero_reg;

    // Products, one multiplier each
    always_comb
    begin
        inter_next  = PW'(ovl_w) * PW'(ovl_h);
        area_a_next = PW'(a_w) * PW'(a_h);
        area_b_next = PW'(b_w) * PW'(b_h);
    end

    assign in_ready = !prod_valid_reg || prod_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            inter_reg  <= inter_next;
            area_a_reg <= area_a_next;
            area_b_reg <= area_b_next;
        end
    end

    // Union; the intersection never exceeds either area, so no wrap
    assign uni_next   = RW'(area_a_reg) + RW'(area_b_reg) - RW'(inter_reg);
    assign prod_ready = !uni_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uni_valid_reg <= 1'b0;
        end
        else if (prod_ready)
        begin
            uni_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_valid_reg && prod_ready)
        begin
            inter_u_reg <= RW'(inter_reg);
            uni_reg     <= uni_next;
            zero_reg    <= (uni_next == '0);
        end
    end

    assign out_valid = uni_valid_reg;
    assign inter     = inter_u_reg;
    assign uni       = uni_reg;
    assign uni_zero  = zero_reg;

endmodule

`default_nettype wire

// ----- hdl/biou_div_cell.sv -----
// ----------------------------------------------------------------------------
// biou_div_cell
// One restoring-division step: compare, subtract, shift in one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module biou_div_cell
    import biou_pkg::*;
#(
    parameter int REM_WIDTH = 2 * BIOU_COORD_WIDTH + 1,
    parameter int QUO_WIDTH = BIOU_FRAC_BITS + 1,
    parameter bit SHIFT     = 1'b1
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [REM_WIDTH-1:0]   in_rem,
    input  wire logic [REM_WIDTH-1:0]   in_div,
    input  wire logic [QUO_WIDTH-1:0]   in_quo,
    input  wire logic                   in_zero,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [REM_WIDTH-1:0]        out_rem,
    output logic [REM_WIDTH-1:0]        out_div,
    output logic [QUO_WIDTH-1:0]        out_quo,
    output logic                        out_zero
);

    localparam int RW = REM_WIDTH;

    logic          valid_reg;
    logic [RW-1:0] rem_reg, div_reg;
    logic [QUO_WIDTH-1:0] quo_reg;
    logic          zero_reg;

    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          ge;
    logic [RW-1:0] rem_next;
    logic [QUO_WIDTH-1:0] quo_next;

    // Trial remainder against the divisor; a zero union yields zero quotient bits
    always_comb
    begin
        trial    = SHIFT ? {in_rem, 1'b0} : {1'b0, in_rem};
        ge       = (trial >= {1'b0, in_div});
        diff     = trial - {1'b0, in_div};
        rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
        quo_next = {in_quo[QUO_WIDTH-2:0], ge && !in_zero};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Hand the partial result to the next cell
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            quo_reg  <= quo_next;
            zero_reg <= in_zero;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_quo   = quo_reg;
    assign out_zero  = zero_reg;

endmodule

`default_nettype wire

// ----- hdl/box_iou.sv -----
// ----------------------------------------------------------------------------
// box_iou
// Intersection over union of two axis-aligned boxes as a fixed-point ratio.
// ----------------------------------------------------------------------------
// Takes one box pair per clock and returns floor(inter * 2^RATIO_FRAC_BITS /
// union), where 2^RATIO_FRAC_BITS means one, together with a flag that is set
// (and the ratio zero) when both boxes have zero area. The registered stages are
// the edge differences, the area products and the union, then a row of
// RATIO_FRAC_BITS + 1 division cells, each a single compare and subtract on
// 2*COORD_WIDTH + 1 bits. Every stage holds one pair, so a new pair is taken
// each cycle and a stalled output only holds the pipe once all stages are full.
`default_nettype none

`include "box_iou_macros.svh"

module box_iou
    import biou_pkg::*;
#(
    parameter int COORD_WIDTH     = BIOU_COORD_WIDTH,
    parameter int RATIO_FRAC_BITS = BIOU_FRAC_BITS
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
    input  wire logic [8*COORD_WIDTH-1:0]   s_tdata,
    input  wire logic   s_tvalid,
    output logic        s_tready,
    // overlap_ratio, union_zero, zero fill
    output logic [biou_byte_bits(RATIO_FRAC_BITS+2)-1:0] m_tdata,
    output logic        m_tvalid,
    input  wire logic   m_tready
);

    localparam int W      = COORD_WIDTH;
    localparam int RW     = 2 * W + 1;
    localparam int QW     = RATIO_FRAC_BITS + 1;
    localparam int NCELL  = RATIO_FRAC_BITS + 1;
    localparam int OUT_W  = biou_byte_bits(RATIO_FRAC_BITS + 2);
    localparam logic [QW-1:0] RATIO_ONE = QW'(1) << RATIO_FRAC_BITS;

    logic         geo_valid, geo_ready;
    logic [W-1:0] ovl_w, ovl_h, a_w, a_h, b_w, b_h;

    logic          cell_valid [NCELL+1];
    logic          cell_ready [NCELL+1];
    logic [RW-1:0] cell_rem   [NCELL+1];
    logic [RW-1:0] cell_div   [NCELL+1];
    logic [QW-1:0] cell_quo   [NCELL+1];
    logic          cell_zero  [NCELL+1];

    logic [QW-1:0] ratio;
    logic          uni_zero;

    // Edge differences
    biou_geom #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (geo_valid),
        .out_ready (geo_ready),
        .ovl_w     (ovl_w),
        .ovl_h     (ovl_h),
        .a_w       (a_w),
        .a_h       (a_h),
        .b_w       (b_w),
        .b_h       (b_h)
    );

    // Areas and union
    biou_area #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_area (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geo_valid),
        .in_ready  (geo_ready),
        .ovl_w     (ovl_w),
        .ovl_h     (ovl_h),
        .a_w       (a_w),
        .a_h       (a_h),
        .b_w       (b_w),
        .b_h       (b_h),
        .out_valid (cell_valid[0]),
        .out_ready (cell_ready[0]),
        .inter     (cell_rem[0]),
        .uni       (cell_div[0]),
        .uni_zero  (cell_zero[0])
    );

    assign cell_quo[0] = '0;

    // Division row: the first cell settles the integer bit, the rest the fraction
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        biou_div_cell #(
            .REM_WIDTH (RW),
            .QUO_WIDTH (QW),
            .SHIFT     (i != 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_rem    (cell_rem[i]),
            .in_div    (cell_div[i]),
            .in_quo    (cell_quo[i]),
            .in_zero   (cell_zero[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_rem   (cell_rem[i+1]),
            .out_div   (cell_div[i+1]),
            .out_quo   (cell_quo[i+1]),
            .out_zero  (cell_zero[i+1])
        );
    end

    // Result from the last cell
    assign ratio             = cell_quo[NCELL];
    assign uni_zero          = cell_zero[NCELL];
    assign cell_ready[NCELL] = m_tready;
    assign m_tvalid          = cell_valid[NCELL];
    assign m_tdata           = OUT_W'({uni_zero, ratio});

    // Ratio never exceeds one
    `BIOU_ASSERT_IMP(a_ratio_max, clk, rst_n, m_tvalid, ratio <= RATIO_ONE)

    // Zero union gives a zero ratio
    `BIOU_ASSERT_IMP(a_zero_ratio, clk, rst_n, m_tvalid && uni_zero, ratio == '0)

    // A full ratio of one carries no fraction bits
    `BIOU_ASSERT_IMP(a_one_exact, clk, rst_n, m_tvalid && ratio[QW-1], ratio == RATIO_ONE)

endmodule

`default_nettype wire

// ----- test/tb_box_iou.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_iou
// Self-checking bench for the box intersection-over-union block.
// ----------------------------------------------------------------------------
// Streams box pairs into the block: a directed set of corner cases first,
// then random pairs. Most random pairs are overlapping boxes of mixed sizes,
// and the rest are raw random words, disjoint, degenerate and inverted
// boxes. A scoreboard predicts each ratio and flag with exact integer
// arithmetic and compares them in order with what the block returns. Both
// stream sides pause in random bursts, except in the closing stretch.
module tb_box_iou
    import biou_pkg::*;
();

    localparam int CW        = BIOU_COORD_WIDTH;
    localparam int FRAC      = BIOU_FRAC_BITS;
    localparam int RATIO_W   = FRAC + 1;
    localparam int OUT_W     = biou_byte_bits(FRAC + 2);
    localparam int PIPE_LAT  = FRAC + 4;
    localparam int N_RANDOM  = 1130;
    localparam int N_TAIL    = 150;
    localparam int STALL_MAX = 2000;

    // First field in the lowest bits
    typedef struct packed {
        logic signed [CW-1:0] b_bottom;
        logic signed [CW-1:0] b_right;
        logic signed [CW-1:0] b_top;
        logic signed [CW-1:0] b_left;
        logic signed [CW-1:0] a_bottom;
        logic signed [CW-1:0] a_right;
        logic signed [CW-1:0] a_top;
        logic signed [CW-1:0] a_left;
    } box_pair_t;

    typedef struct {
        logic [RATIO_W-1:0] ratio;
        logic               union_zero;
    } iou_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: exact IoU prediction and in-order comparison
    // ------------------------------------------------------------------------
    class iou_scoreboard;
        iou_result_t pending_ratios[$];
        int          errors;

        function iou_result_t predict_iou(box_pair_t p);
            longint          x1, y1, x2, y2, ow, oh, wa, ha, wb, hb;
            longint unsigned inter, area_a, area_b, uni;
            iou_result_t     r;
            x1 = ($signed(p.a_left) > $signed(p.b_left))     ? p.a_left   : p.b_left;
            y1 = ($signed(p.a_top) > $signed(p.b_top))       ? p.a_top    : p.b_top;
            x2 = ($signed(p.a_right) < $signed(p.b_right))   ? p.a_right  : p.b_right;
            y2 = ($signed(p.a_bottom) < $signed(p.b_bottom)) ? p.a_bottom : p.b_bottom;
            ow = (x2 > x1) ? x2 - x1 : 0;
            oh = (y2 > y1) ? y2 - y1 : 0;
            wa = longint'(p.a_right) - longint'(p.a_left);
            ha = longint'(p.a_bottom) - longint'(p.a_top);
            wb = longint'(p.b_right) - longint'(p.b_left);
            hb = longint'(p.b_bottom) - longint'(p.b_top);
            if (wa < 0) wa = -wa;
            if (ha < 0) ha = -ha;
            if (wb < 0) wb = -wb;
            if (hb < 0) hb = -hb;
            inter  = ow * oh;
            area_a = wa * ha;
            area_b = wb * hb;
            uni    = area_a + area_b - inter;
            r.ratio      = '0;
            r.union_zero = 1'b0;
            // Both boxes empty: flag and force zero
            if (uni == 0)
                r.union_zero = 1'b1;
            else if (inter >= uni)
                r.ratio = RATIO_W'(1) << FRAC;
            else
                r.ratio = RATIO_W'((inter << FRAC) / uni);
            return r;
        endfunction

        function void note_pair(box_pair_t p);
            pending_ratios.push_back(predict_iou(p));
        endfunction

        function void check_result(logic [OUT_W-1:0] word);
            iou_result_t want;
            logic [RATIO_W-1:0] got_ratio;
            logic               got_flag;
            got_ratio = word[RATIO_W-1:0];
            got_flag  = word[RATIO_W];
            if (pending_ratios.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: ratio=%0d union_zero=%0b",
                             got_ratio, got_flag);
                return;
            end
            want = pending_ratios.pop_front();
            if (got_ratio !== want.ratio || got_flag !== want.union_zero)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: ratio exp=%0d got=%0d, union_zero exp=%0b got=%0b",
                             want.ratio, got_ratio, want.union_zero, got_flag);
            end
        endfunction
    endclass

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic [8*CW-1:0]    s_tdata  = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;

    iou_scoreboard      sb;
    bit                 calm_tail = 1'b0;
    int                 idle_cycles = 0;

    box_iou u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),   // a_left, a_top, a_right, a_bottom, b_left .. b_bottom
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),   // overlap_ratio, union_zero, zero fill
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #5 clk = ~clk;

    // Record every transfer on both sides
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_pair(box_pair_t'(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_MAX)
        begin
            $display("box_iou test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drop ready in random bursts until the closing stretch
    always
    begin
        @(posedge clk);
        if (rst_n && !calm_tail && $urandom_range(0, 7) == 0)
        begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        m_tready <= 1'b1;
    end

    function automatic logic signed [CW-1:0] to_coord(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return CW'(v);
    endfunction

    // Hold one pair until it transfers, with an optional gap ahead of it
    task automatic send_pair(box_pair_t p);
        if (!calm_tail && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tdata  <= p;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_coords(int al, int at, int ar, int ab,
                               int bl, int bt, int br, int bb);
        box_pair_t p;
        p.a_left   = to_coord(al);
        p.a_top    = to_coord(at);
        p.a_right  = to_coord(ar);
        p.a_bottom = to_coord(ab);
        p.b_left   = to_coord(bl);
        p.b_top    = to_coord(bt);
        p.b_right  = to_coord(br);
        p.b_bottom = to_coord(bb);
        send_pair(p);
    endtask

    // Mostly overlapping boxes; some raw, disjoint, degenerate or inverted
    function automatic box_pair_t random_pair();
        int        kind, span, ax, ay, aw, ah, bx, by, bw, bh;
        box_pair_t p;
        logic signed [CW-1:0] tmp;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            p = {$urandom, $urandom, $urandom, $urandom};
            return p;
        end
        span = ($urandom_range(0, 9) == 0) ? 65535 :
               ($urandom_range(0, 3) == 0) ? 4000 : 300;
        aw = $urandom_range(0, span);
        ah = $urandom_range(0, span);
        bw = $urandom_range(0, span);
        bh = $urandom_range(0, span);
        ax = int'($urandom_range(0, 65535)) - 32768;
        ay = int'($urandom_range(0, 65535)) - 32768;
        if (kind < 25)
        begin
            // disjoint or touching in one axis
            bx = ax + aw + int'($urandom_range(0, 20));
            by = ay - bh + int'($urandom_range(0, ah + bh));
        end
        else
        begin
            bx = ax - bw + int'($urandom_range(0, aw + bw));
            by = ay - bh + int'($urandom_range(0, ah + bh));
        end
        // degenerate boxes of zero width or height
        if (kind >= 25 && kind < 37)
        begin
            if ($urandom_range(0, 1)) aw = 0; else ah = 0;
            if ($urandom_range(0, 1))
            begin
                if ($urandom_range(0, 1)) bw = 0; else bh = 0;
            end
        end
        p.a_left   = to_coord(ax);
        p.a_top    = to_coord(ay);
        p.a_right  = to_coord(ax + aw);
        p.a_bottom = to_coord(ay + ah);
        p.b_left   = to_coord(bx);
        p.b_top    = to_coord(by);
        p.b_right  = to_coord(bx + bw);
        p.b_bottom = to_coord(by + bh);
        // inverted edges
        if (kind >= 88)
        begin
            if ($urandom_range(0, 1))
            begin
                tmp = p.a_left; p.a_left = p.a_right; p.a_right = tmp;
            end
            if ($urandom_range(0, 1))
            begin
                tmp = p.b_top; p.b_top = p.b_bottom; p.b_bottom = tmp;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                tmp = p.a_top; p.a_top = p.a_bottom; p.a_bottom = tmp;
                tmp = p.b_left; p.b_left = p.b_right; p.b_right = tmp;
            end
        end
        return p;
    endfunction

    initial
    begin
        sb = new();

        // Reset once
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner cases
        send_coords(0, 0, 10, 10, 0, 0, 10, 10);
        send_coords(0, 0, 10, 10, 20, 20, 30, 30);
        send_coords(0, 0, 10, 10, 10, 0, 20, 10);
        send_coords(5, 5, 5, 5, 7, 7, 7, 7);
        send_coords(0, 0, 10, 0, 0, 0, 0, 10);
        send_coords(0, 0, 10, 10, 5, 5, 5, 5);
        send_coords(0, 0, 100, 100, 25, 25, 75, 75);
        send_coords(0, 0, 3, 3, 1, 1, 4, 4);
        send_coords(10, 10, 0, 0, 0, 0, 10, 10);
        send_coords(10, 10, 0, 0, 10, 10, 0, 0);
        send_coords(0, 10, 10, 0, 0, 0, 10, 10);
        send_coords(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        send_coords(-32768, -32768, 32767, 32767, 0, 0, 1, 1);
        send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_coords(32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767);
        send_coords(-21846, 21845, 21845, -21846, -21846, -21846, 21845, 21845);
        send_coords(0, 0, 1000, 1000, 0, 0, 1000, 999);
        send_coords(0, 0, 256, 256, 0, 0, 1, 1);
        send_coords(-32768, 0, 32767, 1, 0, -32768, 1, 32767);

        // Random pairs, closing stretch without pauses
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - N_TAIL)
                calm_tail = 1'b1;
            send_pair(random_pair());
        end
        s_tvalid <= 1'b0;

        // Drain, then let the pipe settle
        while (sb.pending_ratios.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);

        if (sb.errors == 0)
            $display("box_iou test passed");
        else
            $display("box_iou test failed");
        $finish;
    end

endmodule

// ----- box_iou.f -----
+incdir+hdl
hdl/biou_pkg.sv
hdl/biou_geom.sv
hdl/biou_area.sv
hdl/biou_div_cell.sv
hdl/box_iou.sv
test/tb_box_iou.sv
